### hw/rtl/qrs_pkg.sv
// Package for the quadratic root solver: word types, widths and status codes.
// Used by every module of the block; depends on nothing.
package qrs_pkg;

  localparam int CW = 32;              // coefficient width
  localparam int FB = 16;              // fraction bits
  localparam int DW = 2 * CW + 2;      // discriminant magnitude width
  localparam int SW = DW / 2;          // square root width
  localparam int RW = SW + 2;          // square root remainder width
  localparam int NW = SW + 2;          // signed numerator width
  localparam int QW = NW - 1 + FB;     // quotient magnitude width
  localparam int VW = CW + 1;          // divisor width (2|a|)

  localparam logic [1:0] ST_ZERO   = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_DOUBLE = 2'd2;
  localparam logic [1:0] ST_TWO    = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] coef_c;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [CW-1:0] root_first;
    logic signed [CW-1:0] root_second;
    logic                 overflow;
  } out_t;

  // Classification and coefficients carried alongside the square root.
  typedef struct packed {
    logic [1:0]           status;
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
  } side_t;

  // Status and root signs carried alongside the divider.
  typedef struct packed {
    logic [1:0] status;
    logic       neg1;
    logic       neg2;
  } dside_t;

endpackage

### hw/rtl/qrs_disc.sv
// Front end of the quadratic root solver: magnitudes, products, discriminant
// and classification in four register stages. Depends on qrs_pkg.
module qrs_disc (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  qrs_pkg::in_t               in_data,
  input  logic [31:0]                zero_limit,
  output logic                       out_valid,
  output logic [qrs_pkg::DW-1:0]     out_rad,
  output qrs_pkg::side_t             out_side
);

  localparam int CW = qrs_pkg::CW;
  localparam int FB = qrs_pkg::FB;
  localparam int DW = qrs_pkg::DW;

  // Stage 1: magnitudes and degenerate test.
  logic [3:0]          vld_r;
  logic [CW-1:0]       ma_r, mb_r, mc_r;
  logic                sac_r, deg_r;
  logic signed [CW-1:0] a1_r, b1_r;

  logic [CW-1:0]       ma_nxt, mb_nxt, mc_nxt;

  always_comb begin
    ma_nxt = in_data.coef_a[CW-1] ? CW'(-in_data.coef_a) : CW'(in_data.coef_a);
    mb_nxt = in_data.coef_b[CW-1] ? CW'(-in_data.coef_b) : CW'(in_data.coef_b);
    mc_nxt = in_data.coef_c[CW-1] ? CW'(-in_data.coef_c) : CW'(in_data.coef_c);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r  <= ma_nxt;
      mb_r  <= mb_nxt;
      mc_r  <= mc_nxt;
      sac_r <= in_data.coef_a[CW-1] ^ in_data.coef_c[CW-1];
      deg_r <= {ma_nxt, {FB{1'b0}}} <= {{(CW+FB-32){1'b0}}, zero_limit};
      a1_r  <= in_data.coef_a;
      b1_r  <= in_data.coef_b;
    end
  end

  // Stage 2: the two products.
  logic [2*CW-1:0]      p_r, q_r;
  logic                 sac2_r, deg2_r;
  logic signed [CW-1:0] a2_r, b2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r    <= mb_r * mb_r;
      q_r    <= ma_r * mc_r;
      sac2_r <= sac_r;
      deg2_r <= deg_r;
      a2_r   <= a1_r;
      b2_r   <= b1_r;
    end
  end

  // Stage 3: discriminant magnitude and sign.
  logic [DW-1:0]        p_ext, q_ext, d_nxt;
  logic                 dneg_nxt;
  logic [DW-1:0]        d_r;
  logic                 dneg_r, deg3_r;
  logic signed [CW-1:0] a3_r, b3_r;

  always_comb begin
    p_ext    = {2'b00, p_r};
    q_ext    = {q_r, 2'b00};
    dneg_nxt = 1'b0;
    if (sac2_r) begin
      d_nxt = p_ext + q_ext;
    end else if (p_ext >= q_ext) begin
      d_nxt = p_ext - q_ext;
    end else begin
      d_nxt    = q_ext - p_ext;
      dneg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      dneg_r <= dneg_nxt;
      deg3_r <= deg2_r;
      a3_r   <= a2_r;
      b3_r   <= b2_r;
    end
  end

  // Stage 4: classification. The radicand is cleared unless there are two
  // roots, so that the square root comes out zero for the double root.
  logic          dzero;
  logic [1:0]    st_nxt;
  logic [DW-1:0] rad_r;
  qrs_pkg::side_t side_r;

  always_comb begin
    dzero = (d_r[DW-1:2*CW] == '0) && (d_r[2*CW-1:0] <= {{(2*CW-32){1'b0}}, zero_limit});
    if (deg3_r) begin
      st_nxt = qrs_pkg::ST_ZERO;
    end else if (dzero) begin
      st_nxt = qrs_pkg::ST_DOUBLE;
    end else if (dneg_r) begin
      st_nxt = qrs_pkg::ST_NONE;
    end else begin
      st_nxt = qrs_pkg::ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r         <= (st_nxt == qrs_pkg::ST_TWO) ? d_r : '0;
      side_r.status <= st_nxt;
      side_r.a      <= a3_r;
      side_r.b      <= b3_r;
    end
  end

  assign out_valid = vld_r[3];
  assign out_rad   = rad_r;
  assign out_side  = side_r;

endmodule

### hw/rtl/qrs_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on qrs_pkg.
module qrs_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [qrs_pkg::DW-1:0]  in_rad,
  input  qrs_pkg::side_t          in_side,
  output logic                    out_valid,
  output logic [qrs_pkg::SW-1:0]  out_root,
  output qrs_pkg::side_t          out_side
);

  localparam int DW = qrs_pkg::DW;
  localparam int SW = qrs_pkg::SW;
  localparam int RW = qrs_pkg::RW;

  logic           vld_r  [SW];
  logic [DW-1:0]  rad_r  [SW];
  logic [RW-1:0]  rem_r  [SW];
  logic [SW-1:0]  root_r [SW];
  qrs_pkg::side_t side_r [SW];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic           vld_i;
    logic [DW-1:0]  rad_i;
    logic [RW-1:0]  rem_i;
    logic [SW-1:0]  root_i;
    qrs_pkg::side_t side_i;
    logic [RW+1:0]  rem_sh;
    logic [RW-1:0]  trial;
    logic           take;

    if (k == 0) begin : g_first
      assign vld_i  = in_valid;
      assign rad_i  = in_rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign side_i = side_r[k-1];
    end

    // Bring down the next pair of radicand bits and try the next root bit.
    assign rem_sh = {rem_i, rad_i[DW-1-2*k -: 2]};
    assign trial  = {root_i, 2'b01};
    assign take   = rem_sh >= {2'b00, trial};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= rad_i;
        rem_r[k]  <= take ? RW'(rem_sh - {2'b00, trial}) : RW'(rem_sh);
        root_r[k] <= {root_i[SW-2:0], take};
        side_r[k] <= side_i;
      end
    end
  end

  assign out_valid = vld_r[SW-1];
  assign out_root  = root_r[SW-1];
  assign out_side  = side_r[SW-1];

endmodule

### hw/rtl/qrs_div.sv
// Pipelined restoring divider for both roots, one quotient bit per stage,
// with a numerator set-up stage in front. Depends on qrs_pkg.
module qrs_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [qrs_pkg::SW-1:0]  in_root,
  input  qrs_pkg::side_t          in_side,
  output logic                    out_valid,
  output logic [qrs_pkg::QW-1:0]  out_q1,
  output logic [qrs_pkg::QW-1:0]  out_q2,
  output qrs_pkg::dside_t         out_side
);

  localparam int CW = qrs_pkg::CW;
  localparam int FB = qrs_pkg::FB;
  localparam int SW = qrs_pkg::SW;
  localparam int NW = qrs_pkg::NW;
  localparam int QW = qrs_pkg::QW;
  localparam int VW = qrs_pkg::VW;

  // Set-up stage: numerators -b -/+ s, their magnitudes and the divisor 2|a|.
  logic [NW-1:0]   bneg, num1, num2, m1, m2;
  logic [CW-1:0]   ma;
  logic            vp_r;
  logic [QW-1:0]   n1_r, n2_r;
  logic [VW-1:0]   dv_r;
  qrs_pkg::dside_t ds_r;

  always_comb begin
    bneg = NW'(-{{(NW-CW){in_side.b[CW-1]}}, in_side.b});
    num1 = bneg - {{(NW-SW){1'b0}}, in_root};
    num2 = bneg + {{(NW-SW){1'b0}}, in_root};
    m1   = num1[NW-1] ? NW'(-num1) : num1;
    m2   = num2[NW-1] ? NW'(-num2) : num2;
    ma   = in_side.a[CW-1] ? CW'(-in_side.a) : CW'(in_side.a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (en) begin
      vp_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_r        <= {m1[NW-2:0], {FB{1'b0}}};
      n2_r        <= {m2[NW-2:0], {FB{1'b0}}};
      dv_r        <= {ma, 1'b0};
      ds_r.status <= in_side.status;
      ds_r.neg1   <= num1[NW-1] ^ in_side.a[CW-1];
      ds_r.neg2   <= num2[NW-1] ^ in_side.a[CW-1];
    end
  end

  logic            vld_r [QW];
  logic [QW-1:0]   n1s_r [QW];
  logic [QW-1:0]   n2s_r [QW];
  logic [VW-1:0]   r1_r  [QW];
  logic [VW-1:0]   r2_r  [QW];
  logic [QW-1:0]   q1_r  [QW];
  logic [QW-1:0]   q2_r  [QW];
  logic [VW-1:0]   dvs_r [QW];
  qrs_pkg::dside_t dss_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic            vld_i;
    logic [QW-1:0]   n1_i, n2_i, q1_i, q2_i;
    logic [VW-1:0]   r1_i, r2_i, dv_i;
    qrs_pkg::dside_t ds_i;
    logic [VW:0]     s1, s2;
    logic            t1, t2;

    if (k == 0) begin : g_first
      assign vld_i = vp_r;
      assign n1_i  = n1_r;
      assign n2_i  = n2_r;
      assign r1_i  = '0;
      assign r2_i  = '0;
      assign q1_i  = '0;
      assign q2_i  = '0;
      assign dv_i  = dv_r;
      assign ds_i  = ds_r;
    end else begin : g_next
      assign vld_i = vld_r[k-1];
      assign n1_i  = n1s_r[k-1];
      assign n2_i  = n2s_r[k-1];
      assign r1_i  = r1_r[k-1];
      assign r2_i  = r2_r[k-1];
      assign q1_i  = q1_r[k-1];
      assign q2_i  = q2_r[k-1];
      assign dv_i  = dvs_r[k-1];
      assign ds_i  = dss_r[k-1];
    end

    assign s1 = {r1_i, n1_i[QW-1-k]};
    assign s2 = {r2_i, n2_i[QW-1-k]};
    assign t1 = s1 >= {1'b0, dv_i};
    assign t2 = s2 >= {1'b0, dv_i};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n1s_r[k] <= n1_i;
        n2s_r[k] <= n2_i;
        r1_r[k]  <= t1 ? VW'(s1 - {1'b0, dv_i}) : VW'(s1);
        r2_r[k]  <= t2 ? VW'(s2 - {1'b0, dv_i}) : VW'(s2);
        q1_r[k]  <= {q1_i[QW-2:0], t1};
        q2_r[k]  <= {q2_i[QW-2:0], t2};
        dvs_r[k] <= dv_i;
        dss_r[k] <= ds_i;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_q1    = q1_r[QW-1];
  assign out_q2    = q2_r[QW-1];
  assign out_side  = dss_r[QW-1];

endmodule

### hw/rtl/quadratic_root_solver_unit.sv
// Quadratic root solver: takes a, b, c in signed Q16.16 and returns status and
// real roots in Q16.16, one word per cycle in and out while the pipeline is not
// held. A word passes through 89 register stages (4 front stages,
// 33 square-root stages, 1 set-up and 50 divide stages, and the output register);
// the one-bit-per-stage square root and divider set that depth. The whole
// pipeline holds while out_stall holds a waiting word, so nothing is lost.
// The zero_limit register is written through cfg_* and should be changed only
// while the pipeline is empty. Depends on qrs_pkg, qrs_disc, qrs_sqrt, qrs_div.
module quadratic_root_solver_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  qrs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output qrs_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data
);

  localparam int CW = qrs_pkg::CW;
  localparam int DW = qrs_pkg::DW;
  localparam int SW = qrs_pkg::SW;
  localparam int QW = qrs_pkg::QW;

  logic [31:0] zero_limit_r;
  logic        en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      zero_limit_r <= cfg_data;
    end
  end

  logic            out_valid_r;
  qrs_pkg::out_t   out_data_r;

  // Every stage advances together unless a finished word is being held.
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  logic            dv;
  logic [DW-1:0]   rad;
  qrs_pkg::side_t  dside;

  qrs_disc u_disc (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .zero_limit (zero_limit_r),
    .out_valid  (dv),
    .out_rad    (rad),
    .out_side   (dside)
  );

  logic            sv;
  logic [SW-1:0]   sroot;
  qrs_pkg::side_t  sside;

  qrs_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv),
    .in_rad    (rad),
    .in_side   (dside),
    .out_valid (sv),
    .out_root  (sroot),
    .out_side  (sside)
  );

  logic            qv;
  logic [QW-1:0]   q1, q2;
  qrs_pkg::dside_t qside;

  qrs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sv),
    .in_root   (sroot),
    .in_side   (sside),
    .out_valid (qv),
    .out_q1    (q1),
    .out_q2    (q2),
    .out_side  (qside)
  );

  // Saturate both quotients to the coefficient range and apply the signs.
  localparam logic [QW-1:0] LIM = QW'(1) << (CW - 1);

  logic [QW-1:0] c1, c2;
  logic          o1, o2, has_roots;
  qrs_pkg::out_t out_nxt;

  always_comb begin
    if (qside.neg1) begin
      o1 = q1 > LIM;
    end else begin
      o1 = q1 > (LIM - QW'(1));
    end
    if (qside.neg2) begin
      o2 = q2 > LIM;
    end else begin
      o2 = q2 > (LIM - QW'(1));
    end
    c1 = o1 ? (qside.neg1 ? LIM : LIM - QW'(1)) : q1;
    c2 = o2 ? (qside.neg2 ? LIM : LIM - QW'(1)) : q2;
    has_roots = (qside.status == qrs_pkg::ST_DOUBLE) || (qside.status == qrs_pkg::ST_TWO);
    out_nxt.status      = qside.status;
    out_nxt.root_first  = '0;
    out_nxt.root_second = '0;
    out_nxt.overflow    = 1'b0;
    if (has_roots) begin
      out_nxt.root_first  = qside.neg1 ? CW'(-c1) : CW'(c1);
      out_nxt.root_second = qside.neg2 ? CW'(-c2) : CW'(c2);
      out_nxt.overflow    = o1 || o2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= qv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_no_root_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == qrs_pkg::ST_ZERO ||
                  out_data.status == qrs_pkg::ST_NONE)
    |-> out_data.root_first == '0 && out_data.root_second == '0 && !out_data.overflow)
    else $error("roots present without a real root");

  a_double_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == qrs_pkg::ST_DOUBLE
    |-> out_data.root_first == out_data.root_second)
    else $error("double root differs");

  a_hold_all: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output word is held");
`endif

endmodule
